[design/gwtm_pkg.sv]
// Shared types and constants of the text measure block.
// Used by the channel interfaces, the config registers, the multiplier and the top level.
`default_nettype none

package gwtm_pkg;

	localparam int SCALE_FRAC_BITS_DEF = 24;

	// field widths
	localparam int CP_W    = 16;
	localparam int ADV_W   = 16;
	localparam int KERN_W  = 16;
	localparam int MAXW_W  = 16;
	localparam int MAXL_W  = 8;
	localparam int SCALE_W = 24;
	localparam int EXT_W   = 17;
	localparam int LINE_W  = 21;
	localparam int LINES_W = 16;
	localparam int OUTW_W  = 20;
	localparam int OUTH_W  = 24;

	// shared multiplier: signed A operand times unsigned B operand
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = SCALE_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

	localparam logic [CP_W-1:0] NEWLINE = CP_W'(10);

	// APB register map
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam logic [2:0] REG_MAX_WIDTH   = 3'd0;
	localparam logic [2:0] REG_SOFT_WRAP   = 3'd1;
	localparam logic [2:0] REG_MAX_LINES   = 3'd2;
	localparam logic [2:0] REG_SCALE       = 3'd3;
	localparam logic [2:0] REG_LINE_EXTENT = 3'd4;

	typedef struct packed {
		logic [MAXW_W-1:0]  max_width;
		logic               soft_wrap;
		logic [MAXL_W-1:0]  max_lines;
		logic [SCALE_W-1:0] scale;
		logic [EXT_W-1:0]   line_extent;
	} cfg_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0]        b;
	} mul_req_t;

endpackage

`default_nettype wire

[design/gwtm_in_if.sv]
// Character request channel of the text measure block.
// Depends on gwtm_pkg for field widths.
`default_nettype none

interface gwtm_in_if
	import gwtm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CP_W-1:0]          codepoint;
	logic [ADV_W-1:0]         advance_units;
	logic signed [KERN_W-1:0] kern_units;
	logic                     last;

	modport source (output valid, codepoint, advance_units, kern_units, last, input ready);
	modport sink (input valid, codepoint, advance_units, kern_units, last, output ready);
endinterface

`default_nettype wire

[design/gwtm_out_if.sv]
// Measurement result channel of the text measure block.
// Depends on gwtm_pkg for field widths.
`default_nettype none

interface gwtm_out_if
	import gwtm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [OUTW_W-1:0]    text_width;
	logic [OUTH_W-1:0]    text_height;
	logic [LINES_W-1:0]   line_count;

	modport source (output valid, text_width, text_height, line_count, input ready);
	modport sink (input valid, text_width, text_height, line_count, output ready);
endinterface

`default_nettype wire

[design/gwtm_cfg.sv]
// APB configuration registers of the text measure block.
// Depends on gwtm_pkg for the register map and cfg_t.
`default_nettype none

module gwtm_cfg
	import gwtm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[APB_AW-1:2];
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_MAX_WIDTH:   cfg_q.max_width   <= pwdata[MAXW_W-1:0];
				REG_SOFT_WRAP:   cfg_q.soft_wrap   <= pwdata[0];
				REG_MAX_LINES:   cfg_q.max_lines   <= pwdata[MAXL_W-1:0];
				REG_SCALE:       cfg_q.scale       <= pwdata[SCALE_W-1:0];
				REG_LINE_EXTENT: cfg_q.line_extent <= pwdata[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_WIDTH:   prdata = APB_DW'(cfg_q.max_width);
			REG_SOFT_WRAP:   prdata = APB_DW'(cfg_q.soft_wrap);
			REG_MAX_LINES:   prdata = APB_DW'(cfg_q.max_lines);
			REG_SCALE:       prdata = APB_DW'(cfg_q.scale);
			REG_LINE_EXTENT: prdata = APB_DW'(cfg_q.line_extent);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[design/gwtm_mul.sv]
// Shared multiplier with registered product and fixed-point rounding of that product.
// Depends on gwtm_pkg for operand widths and mul_req_t.
`default_nettype none

module gwtm_mul
	import gwtm_pkg::*;
#(
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
	localparam int RW = MUL_P_W + 1 - SCALE_FRAC_BITS
) (
	input  wire logic                clk,
	input  mul_req_t                 req,
	output logic signed [MUL_P_W-1:0] prod,
	output logic signed [RW-1:0]      rnd
);

	localparam int RSW = MUL_P_W + 1;
	localparam logic [RSW-1:0] HALF = RSW'(1) << (SCALE_FRAC_BITS - 1);
	localparam logic [RSW-1:0] CEIL = (RSW'(1) << SCALE_FRAC_BITS) - RSW'(1);

	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [RSW-1:0]     sum_r;
	logic signed [RSW-1:0]     adj;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= MUL_P_W'(req.a * $signed({1'b0, req.b}));
		end
	end

	// add one half, then truncate toward zero: negative values round up
	always_comb begin
		sum_r = RSW'(prod_q) + $signed(HALF);
		adj   = sum_r + (sum_r[RSW-1] ? $signed(CEIL) : $signed(RSW'(0)));
	end

	assign prod = prod_q;
	assign rnd  = adj[RSW-1:SCALE_FRAC_BITS];

endmodule

`default_nettype wire

[design/greedy_wrap_text_measure.sv]
// Text measure: each character request runs the shared multiplier on the advance, then the kerning,
// and the next request is taken while the previous one updates the line; the character marked last
// adds line height and height products, passing ADV, UPD, LH and HGT before its result loads the
// output register. Results wait in that register while new characters are taken.
// Async active-low reset clears config registers, line state and the sequencer.
`default_nettype none

module greedy_wrap_text_measure
	import gwtm_pkg::*;
#(
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	gwtm_in_if.sink                char_in,
	gwtm_out_if.source             meas_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int RW   = MUL_P_W + 1 - SCALE_FRAC_BITS;
	localparam int SUMW = ((RW > LINE_W + 1) ? RW : LINE_W + 1) + 2;
	localparam int LW   = ((RW > MUL_B_W + 1) ? RW : MUL_B_W + 1) + 1;
	localparam logic [LINE_W-1:0]  LINE_MAX = '1;
	localparam logic [LINES_W-1:0] LINES_MAX = '1;
	localparam logic [OUTW_W-1:0]  OUTW_MAX = '1;
	localparam logic [OUTH_W-1:0]  OUTH_MAX = '1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADV  = 5'b00010,
		S_UPD  = 5'b00100,
		S_LH   = 5'b01000,
		S_HGT  = 5'b10000
	} state_t;

	cfg_t     cfg;
	mul_req_t mreq;
	state_t   state_q, state_nx;

	logic signed [MUL_P_W-1:0] prod;
	logic signed [RW-1:0]      rnd;

	logic [CP_W-1:0]          cp_q;
	logic signed [KERN_W-1:0] kern_q;
	logic                     last_q;
	logic signed [RW-1:0]     adv_r_q;

	logic [LINE_W-1:0]  cur_q, widest_q, cur_nx, widest_nx;
	logic [LINES_W-1:0] lines_q, lines_nx, lines_inc, lines_out;
	logic               limit_q, limit_nx;

	logic                 out_valid_q;
	logic [OUTW_W-1:0]    out_w_q;
	logic [OUTH_W-1:0]    out_h_q;
	logic [LINES_W-1:0]   out_l_q;

	logic accept, load;
	logic signed [SUMW-1:0] step, cur_s, base, sum, maxw_s;
	logic                   wrap;
	logic signed [LW-1:0]   lh_big;
	logic [MUL_B_W-1:0]     lh;
	logic [LINE_W-1:0]      widest_all;
	logic [LINE_W:0]        w_big;

	gwtm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gwtm_mul #(
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod),
		.rnd  (rnd)
	);

	assign char_in.ready = (state_q == S_IDLE) || (state_q == S_UPD && !last_q);
	assign accept        = char_in.valid && char_in.ready;
	assign load          = (state_q == S_HGT) && (!out_valid_q || meas_out.ready);

	// line count after the limit clamp
	assign lines_out = (cfg.max_lines != '0 && lines_q > LINES_W'(cfg.max_lines))
		? LINES_W'(cfg.max_lines) : lines_q;

	// line height plus margin; anything past 2^24 saturates the height anyway
	always_comb begin
		lh_big = LW'(rnd) + LW'(3);
		lh     = (lh_big > $signed(LW'(1 << OUTH_W))) ? MUL_B_W'(1 << OUTH_W) : lh_big[MUL_B_W-1:0];
	end

	// operand select for the shared multiplier
	always_comb begin
		mreq.en = 1'b0;
		mreq.a  = '0;
		mreq.b  = {1'b0, cfg.scale};
		if (accept) begin
			mreq.en = 1'b1;
			mreq.a  = MUL_A_W'(char_in.advance_units);
		end else begin
			case (state_q)
				S_ADV: begin
					mreq.en = 1'b1;
					mreq.a  = last_q ? '0 : MUL_A_W'(kern_q);
				end
				S_UPD: begin
					mreq.en = last_q;
					mreq.a  = MUL_A_W'(cfg.line_extent);
				end
				S_LH: begin
					mreq.en = 1'b1;
					mreq.a  = MUL_A_W'(lines_out);
					mreq.b  = lh;
				end
				default: ;
			endcase
		end
	end

	// per-character line update
	always_comb begin
		step      = SUMW'(adv_r_q) + SUMW'(rnd);
		cur_s     = $signed(SUMW'(cur_q));
		maxw_s    = $signed(SUMW'(cfg.max_width));
		lines_inc = (lines_q == LINES_MAX) ? lines_q : lines_q + LINES_W'(1);
		cur_nx    = cur_q;
		widest_nx = widest_q;
		lines_nx  = lines_q;
		limit_nx  = limit_q;
		base      = cur_s;
		wrap      = cfg.soft_wrap && cfg.max_width != '0 && (cur_s + step) > maxw_s
			&& cur_q != '0;
		sum       = '0;
		if (!limit_q) begin
			if (cp_q == NEWLINE) begin
				widest_nx = (cur_q > widest_q) ? cur_q : widest_q;
				cur_nx    = '0;
				lines_nx  = lines_inc;
			end else begin
				if (wrap) begin
					widest_nx = (cur_q > widest_q) ? cur_q : widest_q;
					lines_nx  = lines_inc;
					base      = '0;
				end
				sum = base + step;
				if (sum < 0) begin
					cur_nx = '0;
				end else if (sum > $signed(SUMW'(LINE_MAX))) begin
					cur_nx = LINE_MAX;
				end else begin
					cur_nx = sum[LINE_W-1:0];
				end
				if (cfg.max_lines != '0 && lines_nx > LINES_W'(cfg.max_lines)) begin
					limit_nx = 1'b1;
				end
			end
		end
	end

	always_comb begin
		widest_all = (cur_q > widest_q) ? cur_q : widest_q;
		w_big      = (LINE_W + 1)'(widest_all) + (LINE_W + 1)'(4);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (accept) state_nx = S_ADV;
			S_ADV:  state_nx = S_UPD;
			S_UPD: begin
				if (last_q) state_nx = S_LH;
				else if (accept) state_nx = S_ADV;
				else state_nx = S_IDLE;
			end
			S_LH:   state_nx = S_HGT;
			S_HGT:  if (load) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			widest_q <= '0;
			lines_q  <= LINES_W'(1);
			limit_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_UPD) begin
				cur_q    <= cur_nx;
				widest_q <= widest_nx;
				lines_q  <= lines_nx;
				limit_q  <= limit_nx;
			end else if (load) begin
				// drop the string state for the next one
				cur_q    <= '0;
				widest_q <= '0;
				lines_q  <= LINES_W'(1);
				limit_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cp_q   <= char_in.codepoint;
			kern_q <= char_in.kern_units;
			last_q <= char_in.last;
		end
		if (state_q == S_ADV) begin
			adv_r_q <= rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (meas_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_w_q <= (w_big > (LINE_W + 1)'(OUTW_MAX)) ? OUTW_MAX : w_big[OUTW_W-1:0];
			out_h_q <= (prod > $signed(MUL_P_W'(OUTH_MAX))) ? OUTH_MAX : prod[OUTH_W-1:0];
			out_l_q <= lines_out;
		end
	end

	assign meas_out.valid       = out_valid_q;
	assign meas_out.text_width  = out_w_q;
	assign meas_out.text_height = out_h_q;
	assign meas_out.line_count  = out_l_q;

	a_lines_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lines_q != '0)
		else $error("line counter reached zero");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HGT) && (!out_valid_q || meas_out.ready)
		|=> out_valid_q && (state_q == S_IDLE))
		else $error("result not loaded after height product");

	a_no_take_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (state_q == S_UPD) |-> !last_q)
		else $error("request taken while closing a string");

endmodule

`default_nettype wire
